FILE: rtl/prp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement package
// Sizes, types and codes shared by the page replacement unit and its cells.
// ----------------------------------------------------------------------------
package prp_pkg;

    localparam int FRAMES      = 8;
    localparam int OFFSET_BITS = 4;
    localparam int PAGE_BITS   = 8;
    localparam int COUNT_BITS  = 16;

    localparam int VA_BITS       = PAGE_BITS + OFFSET_BITS;
    localparam int FRAME_BITS    = $clog2(FRAMES);
    localparam int PA_BITS       = FRAME_BITS + OFFSET_BITS;
    localparam int RANK_BITS     = $clog2(FRAMES);
    localparam int OLD_RANK_BITS = $clog2(FRAMES + 1);
    localparam int FILL_BITS     = $clog2(FRAMES + 1);
    localparam int SCAN_BITS     = $clog2(FRAMES);
    localparam int KEY_BITS      = (COUNT_BITS > RANK_BITS) ? COUNT_BITS : RANK_BITS;
    localparam int POLICY_BITS   = 2;

    typedef logic [VA_BITS-1:0]       vaddr_t;
    typedef logic [PAGE_BITS-1:0]     page_t;
    typedef logic [OFFSET_BITS-1:0]   offset_t;
    typedef logic [FRAME_BITS-1:0]    frame_t;
    typedef logic [PA_BITS-1:0]       paddr_t;
    typedef logic [RANK_BITS-1:0]     rank_t;
    typedef logic [OLD_RANK_BITS-1:0] old_rank_t;
    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [KEY_BITS-1:0]      key_t;
    typedef logic [POLICY_BITS-1:0]   policy_t;

    localparam policy_t POLICY_FIFO = 2'd0;
    localparam policy_t POLICY_LRU  = 2'd1;
    localparam policy_t POLICY_LFU  = 2'd2;

    // Victim search token passed from cell to cell.
    typedef struct packed {
        logic   vld;
        frame_t frame;
        key_t   key;
    } token_t;

    // Update broadcast to all cells when an access is committed.
    typedef struct packed {
        logic      en;
        logic      load;
        frame_t    target;
        page_t     page;
        old_rank_t old_rank;
    } cmd_t;

endpackage

FILE: rtl/prp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries one virtual address per transfer.
// ----------------------------------------------------------------------------
interface prp_req_if import prp_pkg::*; ();

    logic   valid;
    logic   ready;
    vaddr_t virtual_address;

    modport source (output valid, output virtual_address, input ready);
    modport sink (input valid, input virtual_address, output ready);

endinterface

FILE: rtl/prp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Carries the translation result of one access per transfer.
// ----------------------------------------------------------------------------
interface prp_rsp_if import prp_pkg::*; ();

    logic   valid;
    logic   ready;
    logic   hit;
    frame_t frame;
    paddr_t physical_address;
    logic   evicted_valid;
    page_t  evicted_page;

    modport source (
        output valid, output hit, output frame, output physical_address,
        output evicted_valid, output evicted_page, input ready
    );
    modport sink (
        input valid, input hit, input frame, input physical_address,
        input evicted_valid, input evicted_page, output ready
    );

endinterface

FILE: rtl/page_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement unit
// Translates virtual addresses through a fully associative frame table with
// FIFO, LRU or LFU replacement.
// ----------------------------------------------------------------------------
// Usage:
// A virtual address is taken on the req channel; the result (hit, frame,
// physical address and any evicted page) comes back on the rsp channel, one
// result per address, in order. The user must write the policy register
// through cfg_we/cfg_data only while the unit is idle; the unit does not
// enforce this. The codes are 0 fifo, 1 lru, 2 lfu, and 3 acts as fifo.
// One address is handled at a time. A hit, a fill of a free frame or a FIFO
// eviction passes through accept, table compare and commit before the next
// ready cycle, and the result is valid the cycle after commit.
// LRU and LFU evictions add a scan step before commit, in which the victim
// search token travels down the chain of frame cells, one cell per cycle.
// Reset empties the table, clears all counts, ranks and the FIFO pointer,
// and selects fifo. The result sits in an output register, so a new address
// is accepted while the previous result still waits; if the receiver stalls
// longer, the next access holds in its commit step until the register frees.
// ----------------------------------------------------------------------------
module page_replacement_unit import prp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    prp_req_if.sink      req,
    prp_rsp_if.source    rsp,
    input  logic         cfg_we,
    input  policy_t      cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t              state_reg, state_next;
    vaddr_t              va_reg, va_next;
    logic                hit_reg, hit_next;
    logic                fill_reg, fill_next;
    frame_t              frame_reg, frame_next;
    logic [SCAN_BITS-1:0] scan_cnt_reg, scan_cnt_next;
    frame_t              fifo_victim_reg, fifo_victim_next;
    logic [FILL_BITS-1:0] frames_filled_reg, frames_filled_next;
    policy_t             policy_reg;

    logic                out_valid_reg, out_valid_next;
    logic                out_hit_reg, out_hit_next;
    frame_t              out_frame_reg, out_frame_next;
    paddr_t              out_pa_reg, out_pa_next;
    logic                out_ev_valid_reg, out_ev_valid_next;
    page_t               out_ev_page_reg, out_ev_page_next;

    cmd_t                cmd;
    logic                lfu_mode;
    token_t              tok [FRAMES+1];
    logic                cell_valid [FRAMES];
    page_t               cell_page [FRAMES];
    rank_t               cell_rank [FRAMES];
    logic [FRAMES-1:0]   match;
    frame_t              match_idx;
    page_t               va_page;
    offset_t             va_offset;
    logic                evict;

    assign va_page   = va_reg[VA_BITS-1:OFFSET_BITS];
    assign va_offset = va_reg[OFFSET_BITS-1:0];
    assign lfu_mode  = (policy_reg == POLICY_LFU);
    assign tok[0]    = '0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        prp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .frame_id (frame_t'(i)),
            .lfu_mode (lfu_mode),
            .cmd      (cmd),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1]),
            .valid    (cell_valid[i]),
            .page     (cell_page[i]),
            .rank     (cell_rank[i])
        );
        assign match[i] = cell_valid[i] && (cell_page[i] == va_page);
    end

    // Lowest matching frame wins.
    always_comb
    begin
        match_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                match_idx = frame_t'(i);
            end
        end
    end

    assign evict = !hit_reg && !fill_reg;

    always_comb
    begin
        state_next         = state_reg;
        va_next            = va_reg;
        hit_next           = hit_reg;
        fill_next          = fill_reg;
        frame_next         = frame_reg;
        scan_cnt_next      = scan_cnt_reg;
        fifo_victim_next   = fifo_victim_reg;
        frames_filled_next = frames_filled_reg;
        out_valid_next     = out_valid_reg && !rsp.ready;
        out_hit_next       = out_hit_reg;
        out_frame_next     = out_frame_reg;
        out_pa_next        = out_pa_reg;
        out_ev_valid_next  = out_ev_valid_reg;
        out_ev_page_next   = out_ev_page_reg;
        cmd                = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    va_next    = req.virtual_address;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                hit_next  = |match;
                fill_next = 1'b0;
                if (|match)
                begin
                    frame_next = match_idx;
                    state_next = S_COMMIT;
                end
                else if (frames_filled_reg < FILL_BITS'(FRAMES))
                begin
                    fill_next  = 1'b1;
                    frame_next = frames_filled_reg[FRAME_BITS-1:0];
                    state_next = S_COMMIT;
                end
                else if (policy_reg == POLICY_LRU || policy_reg == POLICY_LFU)
                begin
                    scan_cnt_next = '0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    frame_next       = fifo_victim_reg;
                    fifo_victim_next = (fifo_victim_reg == frame_t'(FRAMES - 1)) ?
                                       '0 : fifo_victim_reg + frame_t'(1);
                    state_next       = S_COMMIT;
                end
            end
            S_SCAN:
            begin
                // The table is unchanged here, so once the token has passed through
                // every cell, the token leaving the last cell names the victim.
                scan_cnt_next = scan_cnt_reg + SCAN_BITS'(1);
                if (scan_cnt_reg == SCAN_BITS'(FRAMES - 1))
                begin
                    frame_next = tok[FRAMES].frame;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    cmd.en       = 1'b1;
                    cmd.load     = !hit_reg;
                    cmd.target   = frame_reg;
                    cmd.page     = va_page;
                    cmd.old_rank = fill_reg ? old_rank_t'(FRAMES) :
                                   OLD_RANK_BITS'(cell_rank[frame_reg]);
                    out_valid_next    = 1'b1;
                    out_hit_next      = hit_reg;
                    out_frame_next    = frame_reg;
                    out_pa_next       = {frame_reg, va_offset};
                    out_ev_valid_next = evict;
                    out_ev_page_next  = evict ? cell_page[frame_reg] : '0;
                    if (fill_reg)
                    begin
                        frames_filled_next = frames_filled_reg + FILL_BITS'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            va_reg            <= '0;
            hit_reg           <= 1'b0;
            fill_reg          <= 1'b0;
            frame_reg         <= '0;
            scan_cnt_reg      <= '0;
            fifo_victim_reg   <= '0;
            frames_filled_reg <= '0;
            policy_reg        <= POLICY_FIFO;
            out_valid_reg     <= 1'b0;
            out_hit_reg       <= 1'b0;
            out_frame_reg     <= '0;
            out_pa_reg        <= '0;
            out_ev_valid_reg  <= 1'b0;
            out_ev_page_reg   <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            va_reg            <= va_next;
            hit_reg           <= hit_next;
            fill_reg          <= fill_next;
            frame_reg         <= frame_next;
            scan_cnt_reg      <= scan_cnt_next;
            fifo_victim_reg   <= fifo_victim_next;
            frames_filled_reg <= frames_filled_next;
            if (cfg_we)
            begin
                policy_reg <= cfg_data;
            end
            out_valid_reg     <= out_valid_next;
            out_hit_reg       <= out_hit_next;
            out_frame_reg     <= out_frame_next;
            out_pa_reg        <= out_pa_next;
            out_ev_valid_reg  <= out_ev_valid_next;
            out_ev_page_reg   <= out_ev_page_next;
        end
    end

    assign req.ready            = (state_reg == S_IDLE);
    assign rsp.valid            = out_valid_reg;
    assign rsp.hit              = out_hit_reg;
    assign rsp.frame            = out_frame_reg;
    assign rsp.physical_address = out_pa_reg;
    assign rsp.evicted_valid    = out_ev_valid_reg;
    assign rsp.evicted_page     = out_ev_page_reg;

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frames_filled_reg <= FILL_BITS'(FRAMES))
        else $error("frame fill count exceeds the table size");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.evicted_valid))
        else $error("a hit reported an eviction");

    a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.evicted_valid) |-> (frames_filled_reg == FILL_BITS'(FRAMES)))
        else $error("eviction while a free frame remained");

    a_fifo_moves_on_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOOKUP) |=> $stable(fifo_victim_reg))
        else $error("fifo pointer moved outside a lookup");

endmodule

FILE: rtl/prp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame cell
// Holds one frame's page, use count and recency rank, and takes part in the
// victim search chain by passing the best candidate so far to its neighbor.
// ----------------------------------------------------------------------------
module prp_cell import prp_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  frame_t frame_id,
    input  logic   lfu_mode,
    input  cmd_t   cmd,
    input  token_t tok_in,
    output token_t tok_out,
    output logic   valid,
    output page_t  page,
    output rank_t  rank
);

    logic   valid_reg, valid_next;
    page_t  page_reg, page_next;
    count_t count_reg, count_next;
    rank_t  rank_reg, rank_next;
    token_t tok_reg, tok_next;
    key_t   key;
    logic   take;

    // A smaller key is a better victim. For LRU the rank is inverted so that
    // the oldest frame has the smallest key.
    assign key  = lfu_mode ? KEY_BITS'(count_reg) : ({KEY_BITS{1'b1}} ^ KEY_BITS'(rank_reg));
    // Strict compare keeps the lower frame index on a tie.
    assign take = !tok_in.vld || (key < tok_in.key);

    always_comb
    begin
        valid_next = valid_reg;
        page_next  = page_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        tok_next   = take ? token_t'{vld: 1'b1, frame: frame_id, key: key} : tok_in;
        if (cmd.en)
        begin
            if (cmd.target == frame_id)
            begin
                rank_next = '0;
                if (cmd.load)
                begin
                    valid_next = 1'b1;
                    page_next  = cmd.page;
                    count_next = count_t'(1);
                end
                else if (count_reg != {COUNT_BITS{1'b1}})
                begin
                    count_next = count_reg + count_t'(1);
                end
            end
            else if (valid_reg && (OLD_RANK_BITS'(rank_reg) < cmd.old_rank))
            begin
                rank_next = rank_reg + rank_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            page_reg  <= '0;
            count_reg <= '0;
            rank_reg  <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            page_reg  <= page_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign valid   = valid_reg;
    assign page    = page_reg;
    assign rank    = rank_reg;

endmodule
